// ----- rtl/cml_pkg.sv -----
// shared types and constants for the centroid match line counter
// no dependencies; imported by cml_dist, centroid_match_line_counter and the testbench
`default_nettype none

package cml_pkg;

    localparam int COORD_W = 12;
    localparam int AREA_W  = 24;
    localparam int PERIM_W = 16;
    localparam int DIST_W  = 2 * COORD_W + 1;   // sum of two squared 12-bit differences
    localparam int LIMIT_W = 2 * COORD_W;       // squared radius
    localparam int TOTAL_W = 32;
    localparam int INDEX_W = 6;
    localparam int CMD_W   = 2;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TRACK  = 2'd2;

    // register select is paddr bit 2
    localparam logic REG_ACTIVATION_LINE = 1'b0;
    localparam logic REG_MAX_DISTANCE    = 1'b1;

    localparam logic [COORD_W-1:0] ACTIVATION_LINE_RST = 12'd240;
    localparam logic [COORD_W-1:0] MAX_DISTANCE_RST    = 12'd50;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [AREA_W-1:0]  area;
        logic [PERIM_W-1:0] perim;
    } cml_entry_t;

    localparam int ENTRY_W = $bits(cml_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_DECIDE
    } cml_state_t;

endpackage

`default_nettype wire

// ----- rtl/cml_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cml_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cml_dist.sv -----
// two-stage squared distance unit shared by every entry of a scan
// depends on cml_pkg
`default_nettype none

module cml_dist (
    input  wire logic                          clk,
    input  wire logic [cml_pkg::COORD_W-1:0]   cur_x,
    input  wire logic [cml_pkg::COORD_W-1:0]   cur_y,
    input  wire logic [cml_pkg::COORD_W-1:0]   ent_x,
    input  wire logic [cml_pkg::COORD_W-1:0]   ent_y,
    output logic      [cml_pkg::DIST_W-1:0]    dist_sq
);

    import cml_pkg::*;

    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [LIMIT_W-1:0] sq_x;
    logic [LIMIT_W-1:0] sq_y;

    assign sq_x = LIMIT_W'(dx_reg) * LIMIT_W'(dx_reg);
    assign sq_y = LIMIT_W'(dy_reg) * LIMIT_W'(dy_reg);

    always_ff @(posedge clk) begin
        dx_reg  <= (cur_x > ent_x) ? (cur_x - ent_x) : (ent_x - cur_x);
        dy_reg  <= (cur_y > ent_y) ? (cur_y - ent_y) : (ent_y - cur_y);
        dist_sq <= DIST_W'(sq_x) + DIST_W'(sq_y);
    end

endmodule

`default_nettype wire

// ----- rtl/centroid_match_line_counter.sv -----
// centroid match line counter: previous-frame table, nearest match and line crossing count
// depends on cml_pkg, cml_ram and cml_dist
//
// usage
//   input words carry a command: clear the table, append an entry or track an object.
//   clear and append produce no result word. command code 3 is ignored.
//   a track word scans the stored entries one per cycle through a ram read, an
//   absolute difference stage and a squared sum stage, keeps the nearest entry
//   strictly inside the radius (lowest index on ties), then rereads the winner.
//   s_ready is high only while no word is in work; one word is in the block at a time.
//   the result sits in an output register, so the next word can be accepted while
//   a result waits; a stalled receiver holds back a track word only at its final step.
//   registers are written over the apb port at byte 0 (activation line) and
//   byte 4 (max distance); pready is always high.
//   reset clears the entry count, the crossing total and the result valid, and
//   loads the register defaults; table contents stay undefined until appended.
`default_nettype none

module centroid_match_line_counter #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cml_pkg::APB_AW-1:0]    paddr,
    input  wire logic [cml_pkg::APB_DW-1:0]    pwdata,
    output logic      [cml_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    // input words
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cml_pkg::CMD_W-1:0]     s_command,
    input  wire logic [cml_pkg::COORD_W-1:0]   s_center_x,
    input  wire logic [cml_pkg::COORD_W-1:0]   s_center_y,
    input  wire logic [cml_pkg::AREA_W-1:0]    s_blob_area,
    input  wire logic [cml_pkg::PERIM_W-1:0]   s_blob_perimeter,
    // result words
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_match_found,
    output logic      [cml_pkg::INDEX_W-1:0]   m_match_index,
    output logic                               m_newly_counted,
    output logic      [cml_pkg::AREA_W-1:0]    m_out_area,
    output logic      [cml_pkg::PERIM_W-1:0]   m_out_perimeter,
    output logic      [cml_pkg::TOTAL_W-1:0]   m_total_count
);

    import cml_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // configuration
    logic [COORD_W-1:0] line_reg;
    logic [COORD_W-1:0] maxdist_reg;
    logic               cfg_wr;

    // control
    cml_state_t         state_reg, state_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      issue_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;

    // scan pipeline tags: ram data, difference, squared sum
    logic               v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]      idx1_reg, idx2_reg, idx3_reg;

    // current object
    logic [COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic [AREA_W-1:0]  cur_area_reg;
    logic [PERIM_W-1:0] cur_perim_reg;
    logic [LIMIT_W-1:0] limit_reg;

    // best match
    logic               found_reg;
    logic [AW-1:0]      best_idx_reg;
    logic [DIST_W-1:0]  best_reg;

    // output register
    logic               m_valid_reg;
    logic               found_out_reg;
    logic [AW-1:0]      idx_out_reg;
    logic               counted_out_reg;
    logic [AREA_W-1:0]  area_out_reg;
    logic [PERIM_W-1:0] perim_out_reg;

    logic               accept;
    logic               do_append;
    logic               issue;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic               load_out;
    logic [DIST_W-1:0]  dist_sq;
    logic               better;
    cml_entry_t         ent;
    cml_entry_t         wr_entry;
    logic               counted;
    logic               replace;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_MAX_DISTANCE) ? APB_DW'(maxdist_reg) : APB_DW'(line_reg);

    assign accept    = s_valid && s_ready;
    assign do_append = accept && (s_command == CMD_APPEND) && (count_reg < DEPTH_C);
    assign wr_entry  = '{x: s_center_x, y: s_center_y, area: s_blob_area,
                         perim: s_blob_perimeter};
    assign ent       = cml_entry_t'(rd_data);

    cml_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH),
        .AW   (AW)
    ) u_table (
        .clk    (aclk),
        .wr_en  (do_append),
        .wr_addr(count_reg[AW-1:0]),
        .wr_data(wr_entry),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    cml_dist u_dist (
        .clk    (aclk),
        .cur_x  (cur_x_reg),
        .cur_y  (cur_y_reg),
        .ent_x  (ent.x),
        .ent_y  (ent.y),
        .dist_sq(dist_sq)
    );

    assign better = v3_reg && (dist_sq < DIST_W'(limit_reg)) && (!found_reg || dist_sq < best_reg);

    // crossing decision on the reread winner
    assign counted = found_reg && (ent.y < line_reg) && (cur_y_reg >= line_reg);
    assign replace = found_reg && (ent.y >= line_reg);

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        issue      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = issue_reg[AW-1:0];
        load_out   = 1'b0;
        total_next = total_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_command == CMD_TRACK) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                issue = issue_reg < count_reg;
                rd_en = issue;
                if (!issue && !v1_reg && !v2_reg && !v3_reg) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                rd_en      = 1'b1;
                rd_addr    = best_idx_reg;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                    if (counted && total_reg != {TOTAL_W{1'b1}}) begin
                        total_next = total_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg    <= ACTIVATION_LINE_RST;
            maxdist_reg <= MAX_DISTANCE_RST;
            count_reg   <= '0;
            total_reg   <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_ACTIVATION_LINE) begin
                    line_reg <= pwdata[COORD_W-1:0];
                end else begin
                    maxdist_reg <= pwdata[COORD_W-1:0];
                end
            end
            if (accept && s_command == CMD_CLEAR) begin
                count_reg <= '0;
            end else if (do_append) begin
                count_reg <= count_reg + 1'b1;
            end
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (accept && s_command == CMD_TRACK) begin
                found_reg <= 1'b0;
            end else if (better) begin
                found_reg <= 1'b1;
            end
            total_reg <= total_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            cur_x_reg     <= s_center_x;
            cur_y_reg     <= s_center_y;
            cur_area_reg  <= s_blob_area;
            cur_perim_reg <= s_blob_perimeter;
            limit_reg     <= LIMIT_W'(maxdist_reg) * LIMIT_W'(maxdist_reg);
            issue_reg     <= '0;
            best_idx_reg  <= '0;
        end else begin
            if (issue) begin
                issue_reg <= issue_reg + 1'b1;
            end
            if (better) begin
                best_idx_reg <= idx3_reg;
            end
        end
        idx1_reg <= issue_reg[AW-1:0];
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        if (better) begin
            best_reg <= dist_sq;
        end
        if (load_out) begin
            found_out_reg   <= found_reg;
            idx_out_reg     <= found_reg ? best_idx_reg : '0;
            counted_out_reg <= counted;
            area_out_reg    <= replace ? ent.area : cur_area_reg;
            perim_out_reg   <= replace ? ent.perim : cur_perim_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_match_found   = found_out_reg;
    assign m_match_index   = INDEX_W'(idx_out_reg);
    assign m_newly_counted = counted_out_reg;
    assign m_out_area      = area_out_reg;
    assign m_out_perimeter = perim_out_reg;
    assign m_total_count   = total_reg;

    // table fill never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    // a held match always lies strictly inside the radius
    a_best_in_radius: assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg && state_reg != ST_IDLE && !$past(accept)) |-> best_reg < DIST_W'(limit_reg))
        else $error("match outside radius");

    // crossing total only ever moves up
    a_total_monotone: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 total_reg >= $past(total_reg))
        else $error("crossing total decreased");

    // a counted result moves the total unless it was already saturated
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && counted && total_reg != {TOTAL_W{1'b1}}) |=>
            total_reg == $past(total_reg) + 1'b1)
        else $error("crossing not counted");

endmodule

`default_nettype wire

// ----- sim/tb_centroid_match_line_counter.sv -----
// self-checking testbench for centroid_match_line_counter: directed words, then random frames
// depends on cml_pkg and the rtl of the block; predicts untyped result words on its own
// drives the apb registers between phases and checks every result word field by field
`default_nettype none

module tb_centroid_match_line_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import cml_pkg::*;

    localparam int TABLE_DEPTH = 64;
    // scan of a full table plus pipeline, with margin
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 24;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int PHASE_WORDS = 265;
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic               counted;
        logic [AREA_W-1:0]  area;
        logic [PERIM_W-1:0] perim;
        logic [TOTAL_W-1:0] total;
    } match_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [AREA_W-1:0]  area;
        logic [PERIM_W-1:0] perim;
        logic               typed;
        match_result_t      want;
    } directed_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [APB_DW-1:0]   pwdata = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command = '0;
    logic [COORD_W-1:0]  s_center_x = '0;
    logic [COORD_W-1:0]  s_center_y = '0;
    logic [AREA_W-1:0]   s_blob_area = '0;
    logic [PERIM_W-1:0]  s_blob_perimeter = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_match_found;
    logic [INDEX_W-1:0]  m_match_index;
    logic                m_newly_counted;
    logic [AREA_W-1:0]   m_out_area;
    logic [PERIM_W-1:0]  m_out_perimeter;
    logic [TOTAL_W-1:0]  m_total_count;

    centroid_match_line_counter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_center_x(s_center_x), .s_center_y(s_center_y),
        .s_blob_area(s_blob_area), .s_blob_perimeter(s_blob_perimeter),
        .m_valid(m_valid), .m_ready(m_ready), .m_match_found(m_match_found),
        .m_match_index(m_match_index), .m_newly_counted(m_newly_counted),
        .m_out_area(m_out_area), .m_out_perimeter(m_out_perimeter),
        .m_total_count(m_total_count)
    );

    // predictor state
    cml_entry_t          prev_entries [TABLE_DEPTH];
    int unsigned         prev_count = 0;
    logic [TOTAL_W-1:0]  crossings = '0;
    logic [COORD_W-1:0]  line_row = ACTIVATION_LINE_RST;
    logic [COORD_W-1:0]  match_radius = MAX_DISTANCE_RST;

    match_result_t       expected_matches [$];
    int unsigned         mismatch_count = 0;
    int unsigned         words_sent = 0;
    int unsigned         cycle_count = 0;
    int unsigned         sender_idle_pct = 38;
    int unsigned         receiver_idle_pct = 62;

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [DIST_W-1:0] squared_gap(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        logic [DIST_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // returns 1 when the word yields a result word
    function automatic bit predict_word(input logic [CMD_W-1:0] cmd,
                                        input logic [COORD_W-1:0] cx,
                                        input logic [COORD_W-1:0] cy,
                                        input logic [AREA_W-1:0] area,
                                        input logic [PERIM_W-1:0] perim,
                                        output match_result_t res);
        logic [DIST_W-1:0] limit_sq;
        logic [DIST_W-1:0] dist_sq;
        logic [DIST_W-1:0] best_sq;
        int unsigned       best_idx;
        bit                found;
        cml_entry_t        hit;
        res = '0;
        best_sq = '0;
        best_idx = 0;
        found = 1'b0;
        case (cmd)
            CMD_CLEAR: begin
                prev_count = 0;
                return 1'b0;
            end
            CMD_APPEND: begin
                if (prev_count < TABLE_DEPTH) begin
                    prev_entries[prev_count] = '{x: cx, y: cy, area: area, perim: perim};
                    prev_count++;
                end
                return 1'b0;
            end
            CMD_TRACK: ;
            default: return 1'b0;
        endcase
        limit_sq = DIST_W'(match_radius) * DIST_W'(match_radius);
        for (int unsigned i = 0; i < prev_count; i++) begin
            dist_sq = squared_gap(cx, prev_entries[i].x) + squared_gap(cy, prev_entries[i].y);
            if (dist_sq < limit_sq && (!found || dist_sq < best_sq)) begin
                best_sq = dist_sq;
                best_idx = i;
                found = 1'b1;
            end
        end
        res.area = area;
        res.perim = perim;
        if (found) begin
            hit = prev_entries[best_idx];
            res.found = 1'b1;
            res.index = best_idx[INDEX_W-1:0];
            if (hit.y < line_row && cy >= line_row) begin
                res.counted = 1'b1;
                if (crossings != '1) crossings++;
            end else if (hit.y >= line_row) begin
                res.area = hit.area;
                res.perim = hit.perim;
            end
        end
        res.total = crossings;
        return 1'b1;
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
            flag_error($sformatf("mismatch %s: expected %0h got %0h", name, want, got));
    endfunction

    always @(posedge aclk) begin
        match_result_t want;
        if (m_valid === 1'b1 && m_ready) begin
            if (expected_matches.size() == 0) begin
                flag_error($sformatf("unexpected result word, total_count %0h", m_total_count));
            end else begin
                want = expected_matches.pop_front();
                check_field("match_found", want.found, m_match_found);
                check_field("match_index", want.index, m_match_index);
                check_field("newly_counted", want.counted, m_newly_counted);
                check_field("out_area", want.area, m_out_area);
                check_field("out_perimeter", want.perim, m_out_perimeter);
                check_field("total_count", want.total, m_total_count);
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // called right after a rising edge; returns at the edge that accepts the word
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] cx,
                             input logic [COORD_W-1:0] cy, input logic [AREA_W-1:0] area,
                             input logic [PERIM_W-1:0] perim, input logic typed,
                             input match_result_t want);
        match_result_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_center_x <= cx;
        s_center_y <= cy;
        s_blob_area <= area;
        s_blob_perimeter <= perim;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (predict_word(cmd, cx, cy, area, perim, predicted))
            expected_matches.push_back(typed ? want : predicted);
        if (cmd != CMD_IGNORED) words_sent++;
    endtask

    task automatic write_register(input logic reg_sel, input logic [COORD_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= {20'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_sel == REG_ACTIVATION_LINE) line_row = value;
        else match_radius = value;
    endtask

    // block is idle once every result word is back and a full scan has had time to end
    task automatic drain_block();
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] c,
                                                      input int spread);
        int v;
        v = int'(c) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[COORD_W-1:0];
    endfunction

    task automatic send_random(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] cx,
                               input logic [COORD_W-1:0] cy);
        send_word(cmd, cx, cy, AREA_W'($urandom), PERIM_W'($urandom), 1'b0, '0);
    endtask

    // frames: clear, a batch of entries, then tracks mostly aimed at them; some random words
    task automatic run_frames(input int unsigned quota);
        int unsigned stop_at;
        int unsigned entries;
        int unsigned tracks;
        int unsigned pick;
        int          spread;
        cml_entry_t  base;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        stop_at = words_sent + quota;
        spread = int'(match_radius) + 3;
        while (words_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_random(CMD_W'($urandom_range(3)), COORD_W'($urandom),
                            COORD_W'($urandom));
            end else begin
                send_random(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom));
                pick = $urandom_range(99);
                if (pick < 80) entries = $urandom_range(1, 8);
                else if (pick < 95) entries = $urandom_range(9, 40);
                else entries = $urandom_range(60, 70);
                repeat (entries) begin
                    cx = COORD_W'($urandom);
                    if ($urandom_range(1)) cy = near_coord(line_row, spread);
                    else cy = COORD_W'($urandom);
                    send_random(CMD_APPEND, cx, cy);
                end
                tracks = $urandom_range(1, 6);
                repeat (tracks) begin
                    if (prev_count > 0 && $urandom_range(99) < 85) begin
                        base = prev_entries[$urandom_range(prev_count - 1)];
                        cx = near_coord(base.x, spread);
                        cy = near_coord(base.y, spread);
                    end else begin
                        cx = COORD_W'($urandom);
                        cy = COORD_W'($urandom);
                    end
                    send_random(CMD_TRACK, cx, cy);
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    localparam logic [AREA_W-1:0]  AMAX = '1;
    localparam logic [PERIM_W-1:0] PMAX = '1;

    // defaults: line 240, radius 50
    directed_word_t directed_rows [17] = '{
        '{CMD_TRACK,   12'd100,  12'd100,  AMAX,       PMAX,        1'b1,
          '{1'b0, 6'd0, 1'b0, AMAX, PMAX, 32'd0}},
        '{CMD_IGNORED, 12'd4095, 12'd4095, AMAX,       PMAX,        1'b0, '0},
        '{CMD_APPEND,  12'd0,    12'd0,    24'd0,      16'd0,       1'b0, '0},
        '{CMD_APPEND,  12'd4095, 12'd4095, AMAX,       PMAX,        1'b0, '0},
        '{CMD_APPEND,  12'd100,  12'd200,  24'd1234,   16'd55,      1'b0, '0},
        // crosses onto the line itself
        '{CMD_TRACK,   12'd110,  12'd240,  24'd777,    16'd9,       1'b1,
          '{1'b1, 6'd2, 1'b1, 24'd777, 16'd9, 32'd1}},
        // entry already past the line: stored area and perimeter come back
        '{CMD_TRACK,   12'd4095, 12'd4095, 24'd5,      16'd6,       1'b1,
          '{1'b1, 6'd1, 1'b0, AMAX, PMAX, 32'd1}},
        '{CMD_TRACK,   12'd0,    12'd0,    24'h5a5a5a, 16'ha5a5,    1'b1,
          '{1'b1, 6'd0, 1'b0, 24'h5a5a5a, 16'ha5a5, 32'd1}},
        '{CMD_APPEND,  12'd6,    12'd0,    24'd42,     16'd43,      1'b0, '0},
        // equal distance to entries 0 and 3, lowest index wins
        '{CMD_TRACK,   12'd3,    12'd0,    24'd11,     16'd12,      1'b1,
          '{1'b1, 6'd0, 1'b0, 24'd11, 16'd12, 32'd1}},
        // exactly at the radius is no match
        '{CMD_TRACK,   12'd0,    12'd50,   24'd13,     16'd14,      1'b1,
          '{1'b0, 6'd0, 1'b0, 24'd13, 16'd14, 32'd1}},
        '{CMD_TRACK,   12'd0,    12'd49,   24'd15,     16'd16,      1'b1,
          '{1'b1, 6'd0, 1'b0, 24'd15, 16'd16, 32'd1}},
        '{CMD_CLEAR,   12'd0,    12'd0,    24'd0,      16'd0,       1'b0, '0},
        // stale entries after a clear must not match
        '{CMD_TRACK,   12'd0,    12'd0,    24'd1,      16'd2,       1'b1,
          '{1'b0, 6'd0, 1'b0, 24'd1, 16'd2, 32'd1}},
        '{CMD_APPEND,  12'd4000, 12'd239,  24'd100,    16'd200,     1'b0, '0},
        '{CMD_TRACK,   12'd4000, 12'd240,  24'd300,    16'd400,     1'b1,
          '{1'b1, 6'd0, 1'b1, 24'd300, 16'd400, 32'd2}},
        '{CMD_TRACK,   12'd4001, 12'd239,  24'hffff00, 16'h00ff,    1'b0, '0}
    };

    int unsigned phase_line   [6] = '{0, 4095, 2048, 100, 4095, 1000};
    int unsigned phase_radius [6] = '{4095, 0, 100, 1, 4095, 60};

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].x, directed_rows[i].y,
                      directed_rows[i].area, directed_rows[i].perim,
                      directed_rows[i].typed, directed_rows[i].want);
        s_valid <= 1'b0;
        for (int p = 0; p < 6; p++) begin
            drain_block();
            write_register(REG_ACTIVATION_LINE, COORD_W'(phase_line[p]));
            write_register(REG_MAX_DISTANCE, COORD_W'(phase_radius[p]));
            case (p / 2)
                0: begin
                    sender_idle_pct = 38;
                    receiver_idle_pct = 62;
                end
                1: begin
                    sender_idle_pct = 62;
                    receiver_idle_pct = 38;
                end
                default: begin
                    sender_idle_pct = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            run_frames(PHASE_WORDS);
        end
        drain_block();
        if (mismatch_count == 0 && expected_matches.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
